// ===== rtl/generational_handle_allocator_macros.svh =====
// Assertion macros for the generational handle allocator.
// No dependencies; included by the top level only.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Condition a implies condition b in the same cycle.
`define GHA_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Condition a implies condition b in the next cycle.
`define GHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`else

`define GHA_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define GHA_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
// No dependencies; used by the top level and the bench.
package gha_pkg;

    localparam int DEF_SLOTS    = 1024;
    localparam int DEF_GEN_BITS = 8;

    localparam int IDX_IO_W = 10;
    localparam int GEN_IO_W = 8;
    localparam int LIVE_W   = 11;

    typedef logic [IDX_IO_W-1:0] idx_io_t;
    typedef logic [GEN_IO_W-1:0] gen_io_t;
    typedef logic [LIVE_W-1:0]   live_t;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_MARK    = 2'd1,
        OP_DESTROY = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_STALE      = 3'd1,
        ST_NO_FREE    = 3'd2,
        ST_NOT_MARKED = 3'd3,
        ST_NOT_ALLOC  = 3'd4
    } status_t;

    typedef struct packed {
        op_t     operation;
        idx_io_t slot_index;
        gen_io_t handle_generation;
    } req_t;

    typedef struct packed {
        status_t status;
        idx_io_t result_index;
        gen_io_t result_generation;
        logic    handle_valid;
        logic    marked_flag;
        live_t   live_count;
        logic    destroyed_event;
    } rsp_t;

endpackage

// ===== rtl/gha_chan_if.sv =====
// Valid/ready channel carrying one item of type payload_t.
// Used with gha_pkg::req_t and gha_pkg::rsp_t.
interface gha_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: hands out slot/generation handles.
// Depends on gha_pkg, gha_chan_if and generational_handle_allocator_macros.svh.
//
// Channels: req (sink, gha_pkg::req_t) takes one operation per item:
// create, mark, destroy or query. rsp (source, gha_pkg::rsp_t) returns
// exactly one result item per request, in order. Both are valid/ready;
// an item moves on a rising edge with valid and ready high.
// Throughput: one item at a time. The accept edge reads the slot table;
// the S_EXEC step then writes it back and loads the result register.
// A create that reuses a freed slot adds the S_REUSE step: the free
// queue read must finish before the slot table can be read.
// The slot table (generation + mark) and the free queue are synchronous
// RAMs with registered reads; the read-modify-write pair sets the rate.
// Reset: counters and pointers clear at once, no clearing pass. Data read
// from slots at or above the in-use count is never used; a fresh create
// writes its entry as zero generation, unmarked.
// Stall: the result sits in an output register. While it waits, the
// next request is still accepted and executed up to the point of loading
// its own result, where it holds until the register frees.
`include "generational_handle_allocator_macros.svh"

module generational_handle_allocator #(
    parameter int SLOTS    = gha_pkg::DEF_SLOTS,
    parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    gha_chan_if.sink   req,
    gha_chan_if.source rsp
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = GEN_BITS + 1;
    localparam int CMP_W  = CNT_W + gha_pkg::IDX_IO_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;  // read data valid, finish item
    localparam logic [1:0] S_REUSE = 2'd2;  // slot read of a reused slot

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [GEN_BITS-1:0] gen_t;
    typedef logic [CMP_W-1:0]    cmp_t;

    localparam cnt_t SLOTS_CNT = cnt_t'(SLOTS);
    localparam idx_t LAST_IDX  = idx_t'(SLOTS - 1);

    // Memories: slot table {mark, generation} and free slot queue
    logic [WORD_W-1:0] slot_mem [SLOTS];
    logic [WORD_W-1:0] slot_rdata_reg;
    idx_t              fq_mem [SLOTS];
    idx_t              fq_rdata_reg;

    logic              slot_we;
    idx_t              slot_waddr;
    logic [WORD_W-1:0] slot_wdata;
    logic              slot_re;
    idx_t              slot_raddr;
    logic              fq_we;
    logic              fq_re;

    // Control state
    logic [1:0]      state_reg, state_next;
    gha_pkg::op_t    op_reg;
    gha_pkg::idx_io_t idx_reg;
    gha_pkg::gen_io_t hgen_reg;
    idx_t            slot_reg, slot_next;
    idx_t            head_reg, head_next;
    idx_t            tail_reg, tail_next;
    cnt_t            free_count_reg, free_count_next;
    cnt_t            slots_in_use_reg, slots_in_use_next;
    cnt_t            live_total_reg, live_total_next;

    logic            rsp_valid_reg;
    gha_pkg::rsp_t   rsp_payload_reg, rsp_payload_next;
    logic            rsp_load;

    logic            accept;
    logic            out_free;
    logic            fresh;
    logic            has_free;
    logic            reuse_go;
    logic            idx_alloc;
    idx_t            idx_addr;
    gen_t            cur_gen;
    logic            cur_mark;
    gen_t            gen_inc;
    gha_pkg::gen_io_t cur_gen8;
    gha_pkg::gen_io_t inc_gen8;

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    assign fresh     = (slots_in_use_reg < SLOTS_CNT);
    assign has_free  = (free_count_reg != '0);
    assign reuse_go  = (state_reg == S_EXEC) && (op_reg == gha_pkg::OP_CREATE)
                       && !fresh && has_free;
    assign idx_alloc = (cmp_t'(idx_reg) < cmp_t'(slots_in_use_reg));
    assign idx_addr  = idx_t'(idx_reg);

    assign cur_gen  = slot_rdata_reg[GEN_BITS-1:0];
    assign cur_mark = slot_rdata_reg[GEN_BITS];
    assign gen_inc  = cur_gen + gen_t'(1);
    assign cur_gen8 = gha_pkg::gen_io_t'(cur_gen);
    assign inc_gen8 = gha_pkg::gen_io_t'(gen_inc);

    // Read ports: the accept edge reads the addressed slot and the queue
    // head; a reuse create then reads the slot taken from the queue.
    assign slot_re    = accept || reuse_go;
    assign slot_raddr = reuse_go ? fq_rdata_reg : idx_t'(req.payload.slot_index);
    assign fq_re      = accept;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            fq_mem[tail_reg] <= idx_addr;
        end
        if (fq_re)
        begin
            fq_rdata_reg <= fq_mem[head_reg];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        free_count_next   = free_count_reg;
        slots_in_use_next = slots_in_use_reg;
        live_total_next   = live_total_reg;
        slot_we           = 1'b0;
        slot_waddr        = idx_addr;
        slot_wdata        = '0;
        fq_we             = 1'b0;
        rsp_load          = 1'b0;

        rsp_payload_next                   = rsp_payload_reg;
        rsp_payload_next.status            = gha_pkg::ST_OK;
        rsp_payload_next.result_index      = idx_reg;
        rsp_payload_next.result_generation = '0;
        rsp_payload_next.handle_valid      = 1'b0;
        rsp_payload_next.marked_flag       = 1'b0;
        rsp_payload_next.destroyed_event   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (reuse_go)
                begin
                    // pop the oldest freed slot
                    slot_next       = fq_rdata_reg;
                    head_next       = (head_reg == LAST_IDX) ? '0 : head_reg + idx_t'(1);
                    free_count_next = free_count_reg - cnt_t'(1);
                    state_next      = S_REUSE;
                end
                else if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    priority if (op_reg == gha_pkg::OP_CREATE)
                    begin
                        if (fresh)
                        begin
                            slot_we           = 1'b1;
                            slot_waddr        = idx_t'(slots_in_use_reg);
                            slot_wdata        = '0;
                            slots_in_use_next = slots_in_use_reg + cnt_t'(1);
                            if (live_total_reg < SLOTS_CNT)
                            begin
                                live_total_next = live_total_reg + cnt_t'(1);
                            end
                            rsp_payload_next.result_index =
                                gha_pkg::idx_io_t'(slots_in_use_reg);
                            rsp_payload_next.handle_valid = 1'b1;
                        end
                        else
                        begin
                            rsp_payload_next.status       = gha_pkg::ST_NO_FREE;
                            rsp_payload_next.result_index = '0;
                        end
                    end
                    else if (!idx_alloc)
                    begin
                        rsp_payload_next.status = gha_pkg::ST_NOT_ALLOC;
                    end
                    else
                    begin
                        rsp_payload_next.result_generation = cur_gen8;
                        rsp_payload_next.handle_valid      = (cur_gen8 == hgen_reg);
                        unique case (op_reg)
                            gha_pkg::OP_MARK:
                            begin
                                slot_we    = 1'b1;
                                slot_wdata = {1'b1, cur_gen};
                                rsp_payload_next.marked_flag = 1'b1;
                            end
                            gha_pkg::OP_DESTROY:
                            begin
                                if (!cur_mark)
                                begin
                                    rsp_payload_next.status = gha_pkg::ST_NOT_MARKED;
                                end
                                else if (cur_gen8 != hgen_reg)
                                begin
                                    rsp_payload_next.status      = gha_pkg::ST_STALE;
                                    rsp_payload_next.marked_flag = 1'b1;
                                end
                                else
                                begin
                                    slot_we    = 1'b1;
                                    slot_wdata = {1'b1, gen_inc};
                                    // push dropped when the queue is already full
                                    if (free_count_reg < SLOTS_CNT)
                                    begin
                                        fq_we           = 1'b1;
                                        tail_next       = (tail_reg == LAST_IDX) ?
                                                          '0 : tail_reg + idx_t'(1);
                                        free_count_next = free_count_reg + cnt_t'(1);
                                    end
                                    if (live_total_reg != '0)
                                    begin
                                        live_total_next = live_total_reg - cnt_t'(1);
                                    end
                                    rsp_payload_next.result_generation = inc_gen8;
                                    rsp_payload_next.handle_valid =
                                        (inc_gen8 == hgen_reg);
                                    rsp_payload_next.marked_flag     = 1'b1;
                                    rsp_payload_next.destroyed_event = 1'b1;
                                end
                            end
                            gha_pkg::OP_QUERY:
                            begin
                                rsp_payload_next.marked_flag = cur_mark;
                            end
                            gha_pkg::OP_CREATE:
                            begin
                                // handled above
                            end
                        endcase
                    end
                end
            end
            S_REUSE:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    slot_we    = 1'b1;
                    slot_waddr = slot_reg;
                    slot_wdata = {1'b0, cur_gen};
                    if (live_total_reg < SLOTS_CNT)
                    begin
                        live_total_next = live_total_reg + cnt_t'(1);
                    end
                    rsp_payload_next.result_index      = gha_pkg::idx_io_t'(slot_reg);
                    rsp_payload_next.result_generation = cur_gen8;
                    rsp_payload_next.handle_valid      = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_payload_next.live_count = gha_pkg::live_t'(live_total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_reg         <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            free_count_reg   <= '0;
            slots_in_use_reg <= '0;
            live_total_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            free_count_reg   <= free_count_next;
            slots_in_use_reg <= slots_in_use_next;
            live_total_reg   <= live_total_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.payload.operation;
            idx_reg  <= req.payload.slot_index;
            hgen_reg <= req.payload.handle_generation;
        end
        if (rsp_load)
        begin
            rsp_payload_reg <= rsp_payload_next;
        end
    end

    `GHA_ASSERT_IMPLIES(a_free_count_bound, clk, rst_n, 1'b1, free_count_reg <= SLOTS_CNT)
    `GHA_ASSERT_IMPLIES(a_live_bound, clk, rst_n, 1'b1, live_total_reg <= slots_in_use_reg)
    `GHA_ASSERT_IMPLIES(a_reuse_when_full, clk, rst_n, state_reg == S_REUSE, slots_in_use_reg == SLOTS_CNT)
    `GHA_ASSERT_NEXT(a_result_after_load, clk, rst_n, rsp_load, rsp_valid_reg)

endmodule

// ===== bench/tb_generational_handle_allocator.sv =====
// Self-checking bench for generational_handle_allocator: directed rows, then random traffic.
// Depends on gha_pkg, gha_chan_if and the allocator RTL; apart from typed rows, each result
// is checked against an in-file behavioral model of slot generations, marks and free list.
module tb_generational_handle_allocator;

    typedef gha_pkg::req_t    req_t;
    typedef gha_pkg::rsp_t    rsp_t;
    typedef gha_pkg::op_t     op_t;
    typedef gha_pkg::idx_io_t idx_io_t;
    typedef gha_pkg::gen_io_t gen_io_t;
    typedef gha_pkg::live_t   live_t;

    localparam op_t OP_CREATE  = gha_pkg::OP_CREATE;
    localparam op_t OP_MARK    = gha_pkg::OP_MARK;
    localparam op_t OP_DESTROY = gha_pkg::OP_DESTROY;
    localparam op_t OP_QUERY   = gha_pkg::OP_QUERY;

    localparam gha_pkg::status_t ST_OK         = gha_pkg::ST_OK;
    localparam gha_pkg::status_t ST_STALE      = gha_pkg::ST_STALE;
    localparam gha_pkg::status_t ST_NO_FREE    = gha_pkg::ST_NO_FREE;
    localparam gha_pkg::status_t ST_NOT_MARKED = gha_pkg::ST_NOT_MARKED;
    localparam gha_pkg::status_t ST_NOT_ALLOC  = gha_pkg::ST_NOT_ALLOC;

    localparam int SLOTS = gha_pkg::DEF_SLOTS;

    logic clk;
    logic rst_n;

    gha_chan_if #(.payload_t(req_t)) req_ch ();
    gha_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    generational_handle_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Allocator model state: per-slot generation and mark, FIFO of freed
    // slots, fresh-slot watermark and live handle count.
    // ------------------------------------------------------------------
    gen_io_t gen_tbl [SLOTS];
    bit      mark_tbl [SLOTS];
    idx_io_t free_slots [$];
    int      in_use;
    int      live_handles;
    int      dropped_pushes;

    rsp_t expected_results [$];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  op_seen [4];
    int  status_seen [8];
    int  hold_request;   // one-shot long stall handed to the result side
    bit  calm;           // both sides run without gaps while set

    // Directed rows. Rows with typed set carry an expectation read straight off the
    // spec; the rest are checked against the model.
    typedef struct {
        op_t     op;
        idx_io_t idx;
        gen_io_t gen;
        bit      typed;
        rsp_t    want;
    } step_row_t;

    step_row_t directed_rows [24] = '{
        // nothing allocated yet: every slot is out of range
        '{OP_QUERY,   10'd0,    8'd0,    1'b1, '{ST_NOT_ALLOC,  10'd0,    8'd0, 1'b0, 1'b0, 11'd0, 1'b0}},
        '{OP_MARK,    10'd1023, 8'd255,  1'b1, '{ST_NOT_ALLOC,  10'd1023, 8'd0, 1'b0, 1'b0, 11'd0, 1'b0}},
        '{OP_DESTROY, 10'd512,  8'h55,   1'b1, '{ST_NOT_ALLOC,  10'd512,  8'd0, 1'b0, 1'b0, 11'd0, 1'b0}},
        // fresh slots in order; create ignores index and generation
        '{OP_CREATE,  10'd1023, 8'd255,  1'b1, '{ST_OK,         10'd0,    8'd0, 1'b1, 1'b0, 11'd1, 1'b0}},
        '{OP_CREATE,  10'd0,    8'd0,    1'b1, '{ST_OK,         10'd1,    8'd0, 1'b1, 1'b0, 11'd2, 1'b0}},
        '{OP_QUERY,   10'd0,    8'd0,    1'b1, '{ST_OK,         10'd0,    8'd0, 1'b1, 1'b0, 11'd2, 1'b0}},
        '{OP_QUERY,   10'd0,    8'd255,  1'b1, '{ST_OK,         10'd0,    8'd0, 1'b0, 1'b0, 11'd2, 1'b0}},
        // first index past the watermark
        '{OP_QUERY,   10'd2,    8'd0,    1'b1, '{ST_NOT_ALLOC,  10'd2,    8'd0, 1'b0, 1'b0, 11'd2, 1'b0}},
        // destroy without a mark is refused before the generation check
        '{OP_DESTROY, 10'd0,    8'd0,    1'b1, '{ST_NOT_MARKED, 10'd0,    8'd0, 1'b1, 1'b0, 11'd2, 1'b0}},
        '{OP_DESTROY, 10'd1,    8'hAA,   1'b1, '{ST_NOT_MARKED, 10'd1,    8'd0, 1'b0, 1'b0, 11'd2, 1'b0}},
        // mark does not care about the generation
        '{OP_MARK,    10'd0,    8'hAA,   1'b1, '{ST_OK,         10'd0,    8'd0, 1'b0, 1'b1, 11'd2, 1'b0}},
        '{OP_DESTROY, 10'd0,    8'hFF,   1'b1, '{ST_STALE,      10'd0,    8'd0, 1'b0, 1'b1, 11'd2, 1'b0}},
        '{OP_DESTROY, 10'd0,    8'd0,    1'b1, '{ST_OK,         10'd0,    8'd1, 1'b0, 1'b1, 11'd1, 1'b1}},
        // mark survives the destroy
        '{OP_QUERY,   10'd0,    8'd1,    1'b1, '{ST_OK,         10'd0,    8'd1, 1'b1, 1'b1, 11'd1, 1'b0}},
        // re-destroy of a freed slot; live count bottoms out at zero
        '{OP_DESTROY, 10'd0,    8'd1,    1'b1, '{ST_OK,         10'd0,    8'd2, 1'b0, 1'b1, 11'd0, 1'b1}},
        '{OP_DESTROY, 10'd0,    8'd2,    1'b1, '{ST_OK,         10'd0,    8'd3, 1'b0, 1'b1, 11'd0, 1'b1}},
        '{OP_MARK,    10'd1,    8'd0,    1'b1, '{ST_OK,         10'd1,    8'd0, 1'b1, 1'b1, 11'd0, 1'b0}},
        // free list is not used until the pool is fully handed out
        '{OP_CREATE,  10'd0,    8'd0,    1'b1, '{ST_OK,         10'd2,    8'd0, 1'b1, 1'b0, 11'd1, 1'b0}},
        '{OP_QUERY,   10'd1023, 8'd0,    1'b1, '{ST_NOT_ALLOC,  10'd1023, 8'd0, 1'b0, 1'b0, 11'd1, 1'b0}},
        '{OP_QUERY,   10'd1,    8'd0,    1'b0, '0},
        '{OP_CREATE,  10'd512,  8'h80,   1'b0, '0},
        '{OP_MARK,    10'd3,    8'h80,   1'b0, '0},
        '{OP_DESTROY, 10'd3,    8'd0,    1'b0, '0},
        '{OP_DESTROY, 10'd1,    8'd1,    1'b0, '0}
    };

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit, far above the slowest legal run.
    initial
    begin : run_limit
        #(12 * 700000);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model: apply one operation, return the result the block must give.
    // ------------------------------------------------------------------
    function automatic rsp_t handle_outcome(req_t r);
        rsp_t    o;
        int      slot;
        gen_io_t g;
        o = '0;
        o.status = ST_OK;
        if (r.operation == OP_CREATE)
        begin
            slot = -1;
            if (in_use < SLOTS)
            begin
                slot = in_use;
                in_use++;
            end
            else if (free_slots.size() > 0)
            begin
                slot = free_slots[0];
                free_slots.delete(0);
            end
            else
                o.status = ST_NO_FREE;   // pool exhausted, nothing changes
            if (slot >= 0)
            begin
                mark_tbl[slot] = 1'b0;
                if (live_handles < SLOTS)
                    live_handles++;
                o.result_index      = idx_io_t'(slot);
                o.result_generation = gen_tbl[slot];
                o.handle_valid      = 1'b1;
            end
        end
        else if (int'(r.slot_index) >= in_use)
        begin
            o.status       = ST_NOT_ALLOC;
            o.result_index = r.slot_index;
        end
        else
        begin
            g = gen_tbl[r.slot_index];
            o.result_index      = r.slot_index;
            o.result_generation = g;
            o.handle_valid      = (g == r.handle_generation);
            case (r.operation)
                OP_MARK:
                begin
                    mark_tbl[r.slot_index] = 1'b1;
                    o.marked_flag = 1'b1;
                end
                OP_DESTROY:
                begin
                    if (!mark_tbl[r.slot_index])
                        o.status = ST_NOT_MARKED;
                    else if (g != r.handle_generation)
                    begin
                        o.status       = ST_STALE;
                        o.handle_valid = 1'b0;
                        o.marked_flag  = 1'b1;
                    end
                    else
                    begin
                        g = g + 8'd1;   // wraps at the generation width
                        gen_tbl[r.slot_index] = g;
                        if (free_slots.size() < SLOTS)
                            free_slots = {free_slots, r.slot_index};
                        else
                            dropped_pushes++;
                        if (live_handles > 0)
                            live_handles--;
                        o.result_generation = g;
                        o.handle_valid      = (g == r.handle_generation);
                        o.marked_flag       = 1'b1;
                        o.destroyed_event   = 1'b1;
                    end
                end
                default:
                    o.marked_flag = mark_tbl[r.slot_index];
            endcase
        end
        o.live_count = live_t'(live_handles);
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function automatic string field_note(string name, logic [10:0] got, logic [10:0] want);
        return $sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want);
    endfunction

    task automatic check_result(rsp_t got);
        rsp_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
            return;
        end
        want = expected_results[0];
        expected_results.delete(0);
        status_seen[want.status]++;
        if (got.status !== want.status)
            report_mismatch(field_note("status", got.status, want.status));
        if (got.result_index !== want.result_index)
            report_mismatch(field_note("result_index", got.result_index, want.result_index));
        if (got.result_generation !== want.result_generation)
            report_mismatch(field_note("result_generation", got.result_generation,
                                       want.result_generation));
        if (got.handle_valid !== want.handle_valid)
            report_mismatch(field_note("handle_valid", got.handle_valid, want.handle_valid));
        if (got.marked_flag !== want.marked_flag)
            report_mismatch(field_note("marked_flag", got.marked_flag, want.marked_flag));
        if (got.live_count !== want.live_count)
            report_mismatch(field_note("live_count", got.live_count, want.live_count));
        if (got.destroyed_event !== want.destroyed_event)
            report_mismatch(field_note("destroyed_event", got.destroyed_event,
                                       want.destroyed_event));
    endtask

    // ------------------------------------------------------------------
    // Request side. Called at a rising edge; returns at the edge that took the
    // item, or after the idle gap that follows it. valid stays high across a
    // zero gap so it never gets two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send(op_t op, idx_io_t idx, gen_io_t gen, bit typed = 1'b0,
                        rsp_t want = '0);
        req_t r;
        rsp_t predicted;
        int   gap;
        r.operation         = op;
        r.slot_index        = idx;
        r.handle_generation = gen;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge clk); while (!req_ch.ready);
        predicted = handle_outcome(r);
        if (typed)
            predicted = want;
        expected_results = {expected_results, predicted};
        op_seen[op]++;
        items_sent++;
        if (items_sent % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic settle_queue();
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic idx_io_t pick_allocated();
        return idx_io_t'($urandom_range(0, in_use - 1));
    endfunction

    // Mostly the slot's current generation, sometimes a stale one.
    function automatic gen_io_t likely_gen(idx_io_t idx, int unsigned pct);
        return ($urandom_range(0, 99) < pct) ? gen_tbl[idx] : gen_io_t'($urandom_range(0, 255));
    endfunction

    // One random step of normal traffic: creates at the given percentage,
    // otherwise queries, mark+destroy pairs, lone marks/destroys and raw noise.
    task automatic mixed_item(int unsigned create_pct);
        idx_io_t     idx;
        int unsigned pick;
        if ($urandom_range(0, 99) < create_pct)
        begin
            send(OP_CREATE, idx_io_t'($urandom_range(0, 1023)), gen_io_t'($urandom_range(0, 255)));
            return;
        end
        idx  = pick_allocated();
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2:
                send(OP_QUERY, idx, likely_gen(idx, 75));
            3, 4, 5:
            begin
                send(OP_MARK, idx, gen_io_t'($urandom_range(0, 255)));
                send(OP_DESTROY, idx, likely_gen(idx, 80));
            end
            6:
                send(OP_DESTROY, idx, likely_gen(idx, 90));
            7:
                send(OP_MARK, idx, gen_io_t'($urandom_range(0, 255)));
            default:
                send(op_t'($urandom_range(0, 3)), idx_io_t'($urandom_range(0, 1023)),
                     gen_io_t'($urandom_range(0, 255)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, or one long hold when asked for.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else if (calm)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            check_result(rsp_ch.payload);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int      n;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        in_use         = 0;
        live_handles   = 0;
        dropped_pushes = 0;
        mismatches     = 0;
        results_seen   = 0;
        items_sent     = 0;
        hold_request   = 0;
        calm           = 1'b0;
        foreach (gen_tbl[i])
        begin
            gen_tbl[i]  = '0;
            mark_tbl[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[i])
            send(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].gen,
                 directed_rows[i].typed, directed_rows[i].want);
        settle_queue();

        // Hand out every fresh slot. Early on the result side holds off for a
        // long stretch so the output register and the pipe both back up.
        n = 0;
        while (in_use < SLOTS)
        begin
            if (n == 40)
                hold_request = 300;
            mixed_item(88);
            n++;
        end
        settle_queue();

        // Drain the free list through creates, then hit the exhausted pool.
        while (free_slots.size() > 0)
            mixed_item(85);
        repeat (4)
            send(OP_CREATE, idx_io_t'($urandom_range(0, 1023)), gen_io_t'($urandom_range(0, 255)));
        settle_queue();

        // Balanced churn on a full pool, with another long hold on the result side.
        hold_request = 250;
        repeat (150)
            mixed_item(35);
        settle_queue();
        repeat (20) @(posedge clk);

        $display("Sent %0d items: %0d create, %0d mark, %0d destroy, %0d query; %0d pushes dropped",
                 items_sent, op_seen[OP_CREATE], op_seen[OP_MARK], op_seen[OP_DESTROY],
                 op_seen[OP_QUERY], dropped_pushes);
        $display("Outcomes: %0d ok, %0d stale, %0d pool empty, %0d unmarked, %0d out of range",
                 status_seen[ST_OK], status_seen[ST_STALE], status_seen[ST_NO_FREE],
                 status_seen[ST_NOT_MARKED], status_seen[ST_NOT_ALLOC]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
